// ===== rtl/core/dpt_pkg.sv =====
// dpt_pkg: shared widths, codes, types and the arctangent table of the polar dial tracker.
// Used by the channel interfaces, dpt_polar_unit and dial_polar_tracker.
`timescale 1ns / 1ps

package dpt_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int COORD_BITS   = 16;

  // field widths
  localparam int ACTION_W = 2;
  localparam int POINT_W  = 16;
  localparam int ANGLE_W  = 16;
  localparam int DIST_W   = 17;
  localparam int RADIUS_W = 15;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // coordinates keep their low COORD_BITS bits, at most the field width
  localparam int COORD_W  = (COORD_BITS < POINT_W) ? COORD_BITS : POINT_W;
  localparam int DELTA_W  = COORD_W + 1;
  localparam int GUARD_SHIFT = 30;
  // two bits of headroom cover the cordic gain on a diagonal vector
  localparam int CORDIC_W = DELTA_W + GUARD_SHIFT + 2;
  localparam int TURN_W   = 32;

  localparam int SQ_W   = 2 * COORD_W;
  localparam int R2_W   = SQ_W + 1;
  localparam int M2_W   = 2 * RADIUS_W;
  localparam int CMP_W  = (R2_W > M2_W) ? R2_W : M2_W;
  localparam int QUO_W  = 32;
  localparam int ROOT_W = QUO_W / 2;
  localparam int SREM_W = ROOT_W + 2;

  localparam int CNT_W      = 5;
  localparam int DIV_STEPS  = QUO_W;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int TABLE_LEN  = 24;

  localparam logic [TURN_W-1:0]  QUARTER_TURN = 32'h4000_0000;
  localparam logic [TURN_W-1:0]  HALF_TURN    = 32'h8000_0000;
  localparam logic [TURN_W-1:0]  ROUND_HALF   = 32'h0000_8000;
  localparam logic [DIST_W-1:0]  FULL_DIST    = 17'd65536;
  localparam logic [ANGLE_W-1:0] CENTER_ANGLE = 16'd16384;
  localparam logic [RADIUS_W-1:0] MIN_RADIUS  = 15'd1;

  // event codes
  localparam logic [ACTION_W-1:0] ACT_PRESS  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DRAG   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CANCEL = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_SET    = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RADIUS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_DIST = 2'd3;

  typedef enum logic [2:0] {
    PU_IDLE,
    PU_SQUARE,
    PU_SUM,
    PU_CMP,
    PU_ITER,
    PU_ROOT,
    PU_DONE
  } pu_state_t;

  typedef struct packed {
    logic [POINT_W-1:0]  center_x;
    logic [POINT_W-1:0]  center_y;
    logic [RADIUS_W-1:0] max_radius;
  } dpt_cfg_t;

  typedef struct packed {
    logic               done;
    logic [ANGLE_W-1:0] angle;
    logic [DIST_W-1:0]  distance;
  } pu_result_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [TURN_W-1:0] atan_turn(input logic [CNT_W-1:0] idx);
    logic [TURN_W-1:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/dpt_stream_if.sv =====
// dpt_stream_if: valid/ready channels carrying pointer events in and dial values out.
// Depends on dpt_pkg for the field widths.
`timescale 1ns / 1ps

interface dpt_in_if import dpt_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [POINT_W-1:0]  point_x;
  logic [POINT_W-1:0]  point_y;
  logic [ANGLE_W-1:0]  set_angle;
  logic [DIST_W-1:0]   set_distance;

  modport source (output valid, action, point_x, point_y, set_angle, set_distance,
                  input ready);
  modport sink   (input valid, action, point_x, point_y, set_angle, set_distance,
                  output ready);
endinterface

interface dpt_out_if import dpt_pkg::*;;
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle;
  logic [DIST_W-1:0]  distance;

  modport source (output valid, angle, distance, input ready);
  modport sink   (input valid, angle, distance, output ready);
endinterface

// ===== rtl/core/dpt_polar_unit.sv =====
// dpt_polar_unit: sequenced cartesian-to-polar conversion for one drag item.
// Shared cordic step, restoring divider and digit-by-digit square root; uses dpt_pkg.
`timescale 1ns / 1ps

module dpt_polar_unit import dpt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [POINT_W-1:0] point_x,
  input  logic [POINT_W-1:0] point_y,
  input  dpt_cfg_t           cfg,
  output pu_result_t         result
);

  pu_state_t state_r, state_nxt;

  logic signed [DELTA_W-1:0]  dx_r, dy_r;
  logic                       zero_r;
  logic [SQ_W-1:0]            dx2_r, dy2_r;
  logic [M2_W-1:0]            m2_r;
  logic [R2_W-1:0]            r2_r;
  logic                       sat_r;
  logic [M2_W-1:0]            rem_r;
  logic [QUO_W-1:0]           quo_r;
  logic [ROOT_W-1:0]          root_r;
  logic [SREM_W-1:0]          srem_r;
  logic signed [CORDIC_W-1:0] x_r, y_r;
  logic [TURN_W-1:0]          z_r;
  logic [CNT_W-1:0]           cnt_r;

  // offsets from the centre
  logic signed [DELTA_W-1:0] dx_c, dy_c;
  assign dx_c = $signed({1'b0, point_x[COORD_W-1:0]}) - $signed({1'b0, cfg.center_x[COORD_W-1:0]});
  assign dy_c = $signed({1'b0, point_y[COORD_W-1:0]}) - $signed({1'b0, cfg.center_y[COORD_W-1:0]});

  // squares
  logic signed [2*DELTA_W-1:0] dx2_full, dy2_full;
  logic [RADIUS_W-1:0]         m_eff;
  logic [M2_W-1:0]             m2_full;
  assign dx2_full = dx_r * dx_r;
  assign dy2_full = dy_r * dy_r;
  assign m_eff    = (cfg.max_radius == '0) ? MIN_RADIUS : cfg.max_radius;
  assign m2_full  = m_eff * m_eff;

  // cordic start vector, left half plane folded by a half turn
  logic signed [CORDIC_W-1:0] dx_ext, dy_ext, x0, y0;
  assign dx_ext = {{(CORDIC_W-DELTA_W){dx_r[DELTA_W-1]}}, dx_r};
  assign dy_ext = {{(CORDIC_W-DELTA_W){dy_r[DELTA_W-1]}}, dy_r};
  assign x0     = dx_ext <<< GUARD_SHIFT;
  assign y0     = dy_ext <<< GUARD_SHIFT;

  // cordic step
  logic signed [CORDIC_W-1:0] xs, ys;
  logic                       cordic_on;
  assign xs        = x_r >>> cnt_r;
  assign ys        = y_r >>> cnt_r;
  assign cordic_on = ({1'b0, cnt_r} < (CNT_W+1)'(CORDIC_STEPS));

  // divider step
  logic [M2_W:0] div_t;
  logic          div_ge;
  assign div_t  = {rem_r, 1'b0};
  assign div_ge = (div_t >= {1'b0, m2_r});

  // square root step
  logic [SREM_W+1:0] sq_acc, sq_trial;
  logic              sq_ge;
  assign sq_acc   = {srem_r, quo_r[QUO_W-1 -: 2]};
  assign sq_trial = (SREM_W+2)'({root_r, 2'b01});
  assign sq_ge    = (sq_acc >= sq_trial);

  logic [CMP_W-1:0] r2_c, m2_c;
  assign r2_c = CMP_W'(r2_r);
  assign m2_c = CMP_W'(m2_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      PU_IDLE:   if (start) state_nxt = PU_SQUARE;
      PU_SQUARE: state_nxt = PU_SUM;
      PU_SUM:    state_nxt = PU_CMP;
      PU_CMP:    state_nxt = PU_ITER;
      PU_ITER:   if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = PU_ROOT;
      PU_ROOT:   if (cnt_r == CNT_W'(ROOT_STEPS - 1)) state_nxt = PU_DONE;
      PU_DONE:   state_nxt = PU_IDLE;
      default:   state_nxt = PU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PU_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      PU_IDLE: begin
        dx_r   <= dx_c;
        dy_r   <= dy_c;
        zero_r <= (dx_c == '0) && (dy_c == '0);
      end
      PU_SQUARE: begin
        dx2_r <= dx2_full[SQ_W-1:0];
        dy2_r <= dy2_full[SQ_W-1:0];
        m2_r  <= m2_full;
        // up axis is minus y on screen
        if (dx_r[DELTA_W-1]) begin
          x_r <= -x0;
          y_r <= y0;
          z_r <= HALF_TURN;
        end else begin
          x_r <= x0;
          y_r <= -y0;
          z_r <= '0;
        end
      end
      PU_SUM: begin
        r2_r <= R2_W'(dx2_r) + R2_W'(dy2_r);
      end
      PU_CMP: begin
        sat_r  <= (r2_c >= m2_c);
        rem_r  <= M2_W'(r2_c);
        quo_r  <= '0;
        root_r <= '0;
        srem_r <= '0;
        cnt_r  <= '0;
      end
      PU_ITER: begin
        rem_r <= div_ge ? M2_W'(div_t - {1'b0, m2_r}) : M2_W'(div_t);
        quo_r <= {quo_r[QUO_W-2:0], div_ge};
        if (cordic_on) begin
          if (!y_r[CORDIC_W-1]) begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + atan_turn(cnt_r);
          end else begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - atan_turn(cnt_r);
          end
        end
        cnt_r <= (cnt_r == CNT_W'(DIV_STEPS - 1)) ? '0 : cnt_r + 1'b1;
      end
      PU_ROOT: begin
        srem_r <= sq_ge ? SREM_W'(sq_acc - sq_trial) : SREM_W'(sq_acc);
        root_r <= {root_r[ROOT_W-2:0], sq_ge};
        quo_r  <= {quo_r[QUO_W-3:0], 2'b00};
        cnt_r  <= cnt_r + 1'b1;
      end
      PU_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // clockwise from the top, rounded half up to 16 bits
  logic [TURN_W-1:0] z_flip, z_round;
  assign z_flip  = QUARTER_TURN - z_r;
  assign z_round = z_flip + ROUND_HALF;

  always_comb begin
    result.done     = (state_r == PU_DONE);
    result.angle    = zero_r ? CENTER_ANGLE : z_round[TURN_W-1 -: ANGLE_W];
    result.distance = sat_r ? FULL_DIST : DIST_W'(root_r);
  end

endmodule

// ===== rtl/core/dial_polar_tracker.sv =====
// dial_polar_tracker: pointer event handling and dial value state for a polar dial.
// Depends on dpt_pkg, dpt_stream_if and dpt_polar_unit.
`timescale 1ns / 1ps
//
//  channel  dir  handshake            payload
//  in_if    in   valid/ready          action, point_x, point_y, set_angle, set_distance
//  out_if   out  valid/ready          angle, distance
//  cfg_*    in   cfg_we, no stall     cfg_index, cfg_data
//
//  press, cancel and direct set finish at the accept edge; the result sits in the
//  output register in the next cycle.
//  a drag goes from accept to result through setup (square, sum, compare), 32 divider steps with
//  the cordic steps running in the first 16 of them, 16 square root steps, then hand-off.
//  one item at a time: in_if.ready is low while a drag is at work or a result waits
//  unless that result is taken in the same cycle.
//  synchronous active-low reset; no clearing pass.

module dial_polar_tracker import dpt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  dpt_in_if.sink               in_if,
  dpt_out_if.source            out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  dpt_cfg_t           cfg_r;
  logic               track_r;
  logic [ANGLE_W-1:0] cur_angle_r, sav_angle_r, out_angle_r;
  logic [DIST_W-1:0]  cur_dist_r, sav_dist_r, out_dist_r;
  logic               busy_r;
  logic               out_valid_r;

  pu_result_t pu_res;
  logic       accept, start;

  assign in_if.ready = !busy_r && (!out_valid_r || out_if.ready);
  assign accept      = in_if.valid && in_if.ready;
  assign start       = accept && (in_if.action == ACT_DRAG);

  dpt_polar_unit u_polar (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .point_x (in_if.point_x),
    .point_y (in_if.point_y),
    .cfg     (cfg_r),
    .result  (pu_res)
  );

  // value after a non-drag item
  logic [ANGLE_W-1:0] ev_angle;
  logic [DIST_W-1:0]  ev_dist, set_dist, drag_dist;
  assign set_dist  = (in_if.set_distance > FULL_DIST) ? FULL_DIST : in_if.set_distance;
  assign drag_dist = track_r ? pu_res.distance : FULL_DIST;

  always_comb begin
    ev_angle = cur_angle_r;
    ev_dist  = cur_dist_r;
    unique case (in_if.action)
      ACT_PRESS: begin
        ev_angle = cur_angle_r;
        ev_dist  = cur_dist_r;
      end
      ACT_CANCEL: begin
        ev_angle = sav_angle_r;
        ev_dist  = track_r ? sav_dist_r : FULL_DIST;
      end
      ACT_SET: begin
        ev_angle = in_if.set_angle;
        ev_dist  = track_r ? set_dist : FULL_DIST;
      end
      default: begin
        ev_angle = cur_angle_r;
        ev_dist  = cur_dist_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x   <= '0;
      cfg_r.center_y   <= '0;
      cfg_r.max_radius <= MIN_RADIUS;
      track_r          <= 1'b1;
      cur_angle_r      <= '0;
      cur_dist_r       <= FULL_DIST;
      sav_angle_r      <= '0;
      sav_dist_r       <= FULL_DIST;
      busy_r           <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (accept && !start) begin
        cur_angle_r <= ev_angle;
        cur_dist_r  <= ev_dist;
        if (in_if.action == ACT_PRESS) begin
          sav_angle_r <= cur_angle_r;
          sav_dist_r  <= cur_dist_r;
        end
      end
      if (pu_res.done) begin
        cur_angle_r <= pu_res.angle;
        cur_dist_r  <= drag_dist;
      end

      if (start) begin
        busy_r <= 1'b1;
      end else if (pu_res.done) begin
        busy_r <= 1'b0;
      end

      if ((accept && !start) || pu_res.done) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CENTER_X:   cfg_r.center_x   <= cfg_data[POINT_W-1:0];
          CFG_CENTER_Y:   cfg_r.center_y   <= cfg_data[POINT_W-1:0];
          CFG_MAX_RADIUS: cfg_r.max_radius <= cfg_data[RADIUS_W-1:0];
          CFG_TRACK_DIST: begin
            track_r <= cfg_data[0];
            if (!cfg_data[0]) cur_dist_r <= FULL_DIST;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !start) begin
      out_angle_r <= ev_angle;
      out_dist_r  <= ev_dist;
    end else if (pu_res.done) begin
      out_angle_r <= pu_res.angle;
      out_dist_r  <= drag_dist;
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.angle    = out_angle_r;
  assign out_if.distance = out_dist_r;

endmodule
